@@ sv/assert_macros.svh @@
// assertion macros for the i2c pin sequencer checker
// no dependencies; expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked while out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked during reset as well
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/i2cms_pkg.sv @@
// shared types and constants for the i2c master pin sequencer
// no dependencies
`default_nettype none

package i2cms_pkg;

    localparam int CMD_DEPTH_DEF = 4;
    localparam int REQ_W = 3;
    localparam int BYTE_W = 8;

    typedef enum logic [REQ_W-1:0] {
        CMD_START     = 3'd0,
        CMD_STOP      = 3'd1,
        CMD_SEND_BYTE = 3'd2,
        CMD_RECV_BYTE = 3'd3,
        CMD_SEND_ACK  = 3'd4,
        CMD_RECV_ACK  = 3'd5
    } cmd_kind_t;

    // classified command as queued between front and back
    typedef struct packed {
        cmd_kind_t         kind;
        logic [BYTE_W-1:0] data;
    } cmd_t;

endpackage

`default_nettype wire

@@ sv/i2cms_cmd_fifo.sv @@
// short command queue between the front and back ends
// depends on i2cms_pkg
`default_nettype none

module i2cms_cmd_fifo #(
    parameter int DEPTH = i2cms_pkg::CMD_DEPTH_DEF
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               wr_en,
    input  i2cms_pkg::cmd_t   wr_data,
    output logic              full,
    input  wire               rd_en,
    output i2cms_pkg::cmd_t   rd_data,
    output logic              empty
);
    import i2cms_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t            mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_wr, do_rd;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ sv/i2cms_front.sv @@
// front end: accepts bus commands and classifies them for the queue
// depends on i2cms_pkg
`default_nettype none

module i2cms_front (
    input  wire                            push,
    output logic                           full,
    input  wire  [i2cms_pkg::REQ_W-1:0]    req_type,
    input  wire  [i2cms_pkg::BYTE_W-1:0]   tx_byte,
    input  wire                            ack_bit,
    input  wire  [i2cms_pkg::BYTE_W-1:0]   rx_line_bits,
    output logic                           cmd_wr_en,
    output i2cms_pkg::cmd_t                cmd_wr_data,
    input  wire                            cmd_full
);
    import i2cms_pkg::*;

    logic known;

    assign full = cmd_full;

    always_comb
    begin
        known            = 1'b1;
        cmd_wr_data.kind = cmd_kind_t'(req_type);
        cmd_wr_data.data = '0;
        case (req_type)
            CMD_START, CMD_STOP:
            begin
                cmd_wr_data.data = '0;
            end
            CMD_SEND_BYTE:
            begin
                cmd_wr_data.data = tx_byte;
            end
            CMD_RECV_BYTE:
            begin
                cmd_wr_data.data = rx_line_bits;
            end
            CMD_SEND_ACK:
            begin
                cmd_wr_data.data = {{(BYTE_W-1){1'b0}}, ack_bit};
            end
            CMD_RECV_ACK:
            begin
                cmd_wr_data.data = {{(BYTE_W-1){1'b0}}, rx_line_bits[0]};
            end
            default:
            begin
                // unused codes make no pin writes and are dropped
                known            = 1'b0;
                cmd_wr_data.kind = CMD_START;
            end
        endcase
    end

    assign cmd_wr_en = push && !cmd_full && known;

endmodule

`default_nettype wire

@@ sv/i2cms_back.sv @@
// back end: steps through the pin writes of each queued command
// depends on i2cms_pkg; result register feeds the output queue ports
`default_nettype none

module i2cms_back (
    input  wire                            clk,
    input  wire                            rst_n,
    input  i2cms_pkg::cmd_t                cmd_rd_data,
    input  wire                            cmd_empty,
    output logic                           cmd_rd_en,
    output logic                           empty,
    input  wire                            pop,
    output logic                           scl_level,
    output logic                           sda_level,
    output logic                           last,
    output logic [i2cms_pkg::BYTE_W-1:0]   rx_value
);
    import i2cms_pkg::*;

    logic                busy_reg, busy_next;
    cmd_kind_t           kind_reg, kind_next;
    logic [BYTE_W-1:0]   data_reg, data_next;
    logic [2:0]          bit_reg, bit_next;
    logic [1:0]          phase_reg, phase_next;
    logic                scl_reg, scl_next;
    logic                sda_reg, sda_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_scl_reg, out_scl_next;
    logic                out_sda_reg, out_sda_next;
    logic                out_last_reg, out_last_next;
    logic [BYTE_W-1:0]   out_rx_reg, out_rx_next;

    logic                advance;
    logic                step_scl, step_sda, step_last, step_fall;
    logic [BYTE_W-1:0]   step_rx;
    logic [1:0]          step_phase;

    assign advance   = busy_reg && (!out_valid_reg || pop);
    assign cmd_rd_en = !cmd_empty && (!busy_reg || (advance && step_last));

    // pin write for the current step
    always_comb
    begin
        step_scl   = scl_reg;
        step_sda   = sda_reg;
        step_last  = 1'b0;
        step_fall  = 1'b0;
        step_rx    = '0;
        step_phase = phase_reg + 1'b1;
        case (kind_reg)
            CMD_START:
            begin
                case (phase_reg)
                    2'd0:    step_sda = 1'b1;
                    2'd1:    step_scl = 1'b1;
                    2'd2:    step_sda = 1'b0;
                    default:
                    begin
                        step_scl  = 1'b0;
                        step_last = 1'b1;
                    end
                endcase
            end
            CMD_STOP:
            begin
                case (phase_reg)
                    2'd0:    step_sda = 1'b0;
                    2'd1:    step_scl = 1'b1;
                    default:
                    begin
                        step_sda  = 1'b1;
                        step_last = 1'b1;
                    end
                endcase
            end
            CMD_SEND_BYTE, CMD_RECV_BYTE:
            begin
                case (phase_reg)
                    2'd0:
                    begin
                        step_sda = (kind_reg == CMD_SEND_BYTE) ? data_reg[BYTE_W-1] : 1'b1;
                    end
                    2'd1:    step_scl = 1'b1;
                    default:
                    begin
                        step_scl   = 1'b0;
                        step_fall  = 1'b1;
                        step_last  = (bit_reg == 3'd7);
                        step_phase = (kind_reg == CMD_SEND_BYTE) ? 2'd0 : 2'd1;
                        if (kind_reg == CMD_RECV_BYTE && step_last)
                        begin
                            step_rx = data_reg;
                        end
                    end
                endcase
            end
            default:
            begin
                // send ack and receive ack
                case (phase_reg)
                    2'd0:
                    begin
                        step_sda = (kind_reg == CMD_SEND_ACK) ? data_reg[0] : 1'b1;
                    end
                    2'd1:    step_scl = 1'b1;
                    default:
                    begin
                        step_scl  = 1'b0;
                        step_last = 1'b1;
                        if (kind_reg == CMD_RECV_ACK)
                        begin
                            step_rx = data_reg;
                        end
                    end
                endcase
            end
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        kind_next      = kind_reg;
        data_next      = data_reg;
        bit_next       = bit_reg;
        phase_next     = phase_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        out_valid_next = out_valid_reg && !pop;
        out_scl_next   = out_scl_reg;
        out_sda_next   = out_sda_reg;
        out_last_next  = out_last_reg;
        out_rx_next    = out_rx_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_scl_next   = step_scl;
            out_sda_next   = step_sda;
            out_last_next  = step_last;
            out_rx_next    = step_rx;
            scl_next       = step_scl;
            sda_next       = step_sda;
            phase_next     = step_phase;
            if (step_fall)
            begin
                bit_next = bit_reg + 1'b1;
                if (kind_reg == CMD_SEND_BYTE)
                begin
                    data_next = {data_reg[BYTE_W-2:0], 1'b0};
                end
            end
            if (step_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (cmd_rd_en)
        begin
            busy_next  = 1'b1;
            kind_next  = cmd_rd_data.kind;
            data_next  = cmd_rd_data.data;
            bit_next   = '0;
            phase_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            kind_reg      <= CMD_START;
            data_reg      <= '0;
            bit_reg       <= '0;
            phase_reg     <= '0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
            out_scl_reg   <= 1'b1;
            out_sda_reg   <= 1'b1;
            out_last_reg  <= 1'b0;
            out_rx_reg    <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            kind_reg      <= kind_next;
            data_reg      <= data_next;
            bit_reg       <= bit_next;
            phase_reg     <= phase_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            out_valid_reg <= out_valid_next;
            out_scl_reg   <= out_scl_next;
            out_sda_reg   <= out_sda_next;
            out_last_reg  <= out_last_next;
            out_rx_reg    <= out_rx_next;
        end
    end

    assign empty     = !out_valid_reg;
    assign scl_level = out_scl_reg;
    assign sda_level = out_sda_reg;
    assign last      = out_last_reg;
    assign rx_value  = out_rx_reg;

endmodule

`default_nettype wire

@@ sv/i2c_master_pin_sequencer.sv @@
// top level of the i2c master pin sequencer
// depends on i2cms_pkg, i2cms_front, i2cms_cmd_fifo, i2cms_back
//
// channel   direction  handshake           payload
// command   in         push / full         req_type, tx_byte, ack_bit, rx_line_bits
// pin write out        pop / empty         scl_level, sda_level, last, rx_value
//
// one pin write per cycle unless a held result stalls it; the back end sequencer
// sets the rate and steps every command kind through its own pin writes
// a command queue of CMD_DEPTH entries lets commands arrive while one runs
// a taken command passes through the queue and the back end state registers before its first pin write is registered
// reset releases both lines high and empties queue and result register
// a held result stalls the sequencer; full rises once the queue fills up
// unused codes are dropped on entry
`default_nettype none

module i2c_master_pin_sequencer #(
    parameter int CMD_DEPTH = i2cms_pkg::CMD_DEPTH_DEF
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            push,
    output logic                           full,
    input  wire  [i2cms_pkg::REQ_W-1:0]    req_type,
    input  wire  [i2cms_pkg::BYTE_W-1:0]   tx_byte,
    input  wire                            ack_bit,
    input  wire  [i2cms_pkg::BYTE_W-1:0]   rx_line_bits,
    output logic                           empty,
    input  wire                            pop,
    output logic                           scl_level,
    output logic                           sda_level,
    output logic                           last,
    output logic [i2cms_pkg::BYTE_W-1:0]   rx_value
);
    import i2cms_pkg::*;

    cmd_t cmd_wr_data;
    cmd_t cmd_rd_data;
    logic cmd_wr_en;
    logic cmd_full;
    logic cmd_rd_en;
    logic cmd_empty;

    i2cms_front u_front (
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .tx_byte      (tx_byte),
        .ack_bit      (ack_bit),
        .rx_line_bits (rx_line_bits),
        .cmd_wr_en    (cmd_wr_en),
        .cmd_wr_data  (cmd_wr_data),
        .cmd_full     (cmd_full)
    );

    i2cms_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_wr_en),
        .wr_data (cmd_wr_data),
        .full    (cmd_full),
        .rd_en   (cmd_rd_en),
        .rd_data (cmd_rd_data),
        .empty   (cmd_empty)
    );

    i2cms_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_rd_data (cmd_rd_data),
        .cmd_empty   (cmd_empty),
        .cmd_rd_en   (cmd_rd_en),
        .empty       (empty),
        .pop         (pop),
        .scl_level   (scl_level),
        .sda_level   (sda_level),
        .last        (last),
        .rx_value    (rx_value)
    );

endmodule

`default_nettype wire

@@ sv/i2cms_checker.sv @@
// port level checks for the i2c master pin sequencer, bound to the top level
// depends on i2cms_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module i2cms_checker (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            empty,
    input wire                            pop,
    input wire                            scl_level,
    input wire                            sda_level,
    input wire                            last,
    input wire [i2cms_pkg::BYTE_W-1:0]    rx_value
);
    import i2cms_pkg::*;

    `ASSERT_ALWAYS(a_reset_empty, !rst_n |-> empty, "result pending during reset")

    `ASSERT_CLK(a_rx_on_last, (!empty && rx_value != '0) |-> last,
        "rx_value set before last write")

    `ASSERT_CLK(a_one_pin,
        (!empty && pop) ##1 !empty |-> $stable(scl_level) || $stable(sda_level),
        "both pins changed in one write")

    `ASSERT_CLK(a_scl_high_last, (!empty && last && scl_level) |-> sda_level,
        "command ended with scl high and sda low")

    `ASSERT_CLK(a_stall_hold,
        (!empty && !pop) |=> !empty && $stable(scl_level) && $stable(sda_level) && $stable(last),
        "stalled result changed")

endmodule

bind i2c_master_pin_sequencer i2cms_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .scl_level (scl_level),
    .sda_level (sda_level),
    .last      (last),
    .rx_value  (rx_value)
);

`default_nettype wire

@@ verif/tb_top.sv @@
// self-checking testbench for i2c_master_pin_sequencer: i2c commands in, pin writes out
// depends on i2cms_pkg and the i2c_master_pin_sequencer rtl
`timescale 1ns / 100ps

module tb_top;

    import i2cms_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED_A = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED_B = 3'd7;
    localparam int MAX_SHOWN = 10;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES = 30;
    localparam int RANDOM_CMDS = 80;
    localparam int FINAL_CMDS = 20;

    typedef struct packed {
        logic              scl;
        logic              sda;
        logic              last;
        logic [BYTE_W-1:0] rx;
    } pin_write_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              push = 1'b0;
    logic              full;
    logic [REQ_W-1:0]  req_type = '0;
    logic [BYTE_W-1:0] tx_byte = '0;
    logic              ack_bit = 1'b0;
    logic [BYTE_W-1:0] rx_line_bits = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic              scl_level;
    logic              sda_level;
    logic              last;
    logic [BYTE_W-1:0] rx_value;

    pin_write_t expected_writes[$];
    logic       scl_model = 1'b1;
    logic       sda_model = 1'b1;
    bit         no_idle = 1'b0;
    int         long_hold_cycles = 0;
    int         stall_left = 0;
    int         quiet_left = 0;
    int         fail_count = 0;
    int         cmds_sent = 0;
    int         valid_cmds = 0;
    int         writes_seen = 0;
    int         full_waits = 0;

    i2c_master_pin_sequencer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .tx_byte      (tx_byte),
        .ack_bit      (ack_bit),
        .rx_line_bits (rx_line_bits),
        .empty        (empty),
        .pop          (pop),
        .scl_level    (scl_level),
        .sda_level    (sda_level),
        .last         (last),
        .rx_value     (rx_value)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #400_000;
        $display("tb_top: timeout with %0d pin writes outstanding", expected_writes.size());
        $display("tb_top: errors");
        $finish;
    end

    task automatic model_sda(input logic v, input logic fin, input logic [BYTE_W-1:0] rx);
        sda_model = v;
        expected_writes.push_back({scl_model, sda_model, fin, rx});
    endtask

    task automatic model_scl(input logic v, input logic fin, input logic [BYTE_W-1:0] rx);
        scl_model = v;
        expected_writes.push_back({scl_model, sda_model, fin, rx});
    endtask

    task automatic predict_pin_writes(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] tx,
                                      input logic ack, input logic [BYTE_W-1:0] rxl);
        case (req)
            CMD_START:
            begin
                model_sda(1'b1, 1'b0, '0);
                model_scl(1'b1, 1'b0, '0);
                model_sda(1'b0, 1'b0, '0);
                model_scl(1'b0, 1'b1, '0);
            end
            CMD_STOP:
            begin
                model_sda(1'b0, 1'b0, '0);
                model_scl(1'b1, 1'b0, '0);
                model_sda(1'b1, 1'b1, '0);
            end
            CMD_SEND_BYTE:
            begin
                for (int i = BYTE_W - 1; i >= 0; i--)
                begin
                    model_sda(tx[i], 1'b0, '0);
                    model_scl(1'b1, 1'b0, '0);
                    model_scl(1'b0, i == 0, '0);
                end
            end
            CMD_RECV_BYTE:
            begin
                model_sda(1'b1, 1'b0, '0);
                for (int i = BYTE_W - 1; i >= 0; i--)
                begin
                    model_scl(1'b1, 1'b0, '0);
                    model_scl(1'b0, i == 0, (i == 0) ? rxl : '0);
                end
            end
            CMD_SEND_ACK:
            begin
                model_sda(ack, 1'b0, '0);
                model_scl(1'b1, 1'b0, '0);
                model_scl(1'b0, 1'b1, '0);
            end
            CMD_RECV_ACK:
            begin
                model_sda(1'b1, 1'b0, '0);
                model_scl(1'b1, 1'b0, '0);
                model_scl(1'b0, 1'b1, {{(BYTE_W-1){1'b0}}, rxl[0]});
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_failure(input string what, input pin_write_t want, input pin_write_t got);
        fail_count++;
        if (fail_count <= MAX_SHOWN)
            $display("tb_top: %s at pin write %0d: exp scl=%b sda=%b last=%b rx=%h,",
                     what, writes_seen, want.scl, want.sda, want.last, want.rx,
                     " got scl=%b sda=%b last=%b rx=%h",
                     got.scl, got.sda, got.last, got.rx);
    endtask

    task automatic check_pin_write();
        pin_write_t got;
        pin_write_t want;
        got = {scl_level, sda_level, last, rx_value};
        writes_seen++;
        if (expected_writes.size() == 0)
        begin
            report_failure("unexpected write", '0, got);
        end
        else
        begin
            want = expected_writes.pop_front();
            if (got.scl !== want.scl || got.sda !== want.sda || got.last !== want.last ||
                got.rx !== want.rx)
                report_failure("mismatch", want, got);
        end
    endtask

    // result side: checks every popped transaction and drives pop with random stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                check_pin_write();
            if (long_hold_cycles != 0)
            begin
                stall_left = long_hold_cycles;
                long_hold_cycles = 0;
            end
            if (quiet_left > 0)
                quiet_left--;
            else if ($urandom_range(0, 49) == 0)
                quiet_left = $urandom_range(20, 60);
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (!no_idle && quiet_left == 0 && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 8);
                pop <= 1'b0;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    task automatic send_command(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] tx,
                                input logic ack, input logic [BYTE_W-1:0] rxl);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 9);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        req_type <= req;
        tx_byte <= tx;
        ack_bit <= ack;
        rx_line_bits <= rxl;
        do
        begin
            @(posedge clk);
            if (full)
                full_waits++;
        end
        while (full);
        predict_pin_writes(req, tx, ack, rxl);
        cmds_sent++;
        if (req <= CMD_RECV_ACK)
            valid_cmds++;
    endtask

    task automatic send_random(input logic [REQ_W-1:0] req);
        send_command(req, BYTE_W'($urandom), 1'($urandom), BYTE_W'($urandom));
    endtask

    task automatic wait_all_writes(input int settle);
        push <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // mostly well-formed frames with random data, some noise and cut-off frames
    task automatic run_frame();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            repeat ($urandom_range(1, 3))
                send_random(REQ_W'($urandom_range(CMD_START, REQ_UNUSED_B)));
        end
        else
        begin
            send_random(CMD_START);
            send_random(CMD_SEND_BYTE);
            send_random(CMD_RECV_ACK);
            repeat ($urandom_range(0, 4))
            begin
                if ($urandom_range(0, 1))
                begin
                    send_random(CMD_SEND_BYTE);
                    send_random(CMD_RECV_ACK);
                end
                else
                begin
                    send_random(CMD_RECV_BYTE);
                    send_random(CMD_SEND_ACK);
                end
            end
            if (pick != 1)
                send_random(CMD_STOP);
        end
    endtask

    task automatic test_bus_frames();
        send_command(CMD_START, 8'h00, 1'b0, 8'h00);
        send_command(CMD_SEND_BYTE, 8'h00, 1'b0, 8'h00);
        send_command(CMD_SEND_BYTE, 8'hFF, 1'b1, 8'hFF);
        send_command(CMD_SEND_BYTE, 8'hA5, 1'b0, 8'h5A);
        send_command(CMD_RECV_ACK, 8'h00, 1'b0, 8'h00);
        send_command(CMD_RECV_ACK, 8'hFF, 1'b1, 8'hFE);
        send_command(CMD_RECV_ACK, 8'h00, 1'b0, 8'h01);
        send_command(CMD_RECV_BYTE, 8'h00, 1'b0, 8'h00);
        send_command(CMD_RECV_BYTE, 8'hFF, 1'b1, 8'hFF);
        send_command(CMD_RECV_BYTE, 8'h5A, 1'b0, 8'hA5);
        send_command(CMD_SEND_ACK, 8'hFF, 1'b0, 8'hFF);
        send_command(CMD_SEND_ACK, 8'h00, 1'b1, 8'h00);
        send_command(CMD_STOP, 8'h00, 1'b0, 8'h00);
        wait_all_writes(SETTLE_CYCLES);
    endtask

    // unused codes and commands out of bus order
    task automatic test_odd_commands();
        send_command(REQ_UNUSED_A, 8'hFF, 1'b1, 8'hFF);
        send_command(REQ_UNUSED_B, 8'h00, 1'b0, 8'h00);
        send_command(CMD_SEND_BYTE, 8'h3C, 1'b0, 8'hC3);
        send_command(CMD_STOP, 8'h00, 1'b0, 8'h00);
        send_command(CMD_STOP, 8'hFF, 1'b1, 8'hFF);
        send_command(CMD_START, 8'h00, 1'b0, 8'h00);
        send_command(CMD_START, 8'hFF, 1'b1, 8'hFF);
        send_command(CMD_RECV_ACK, 8'h00, 1'b1, 8'hFF);
        send_command(REQ_UNUSED_B, 8'hA5, 1'b1, 8'h5A);
        wait_all_writes(SETTLE_CYCLES);
    endtask

    // receiver holds off while commands keep coming so the command queue fills
    task automatic test_queue_fill();
        long_hold_cycles = HOLD_CYCLES;
        repeat (10)
            send_random(REQ_W'($urandom_range(CMD_START, CMD_RECV_ACK)));
        wait_all_writes(SETTLE_CYCLES);
    endtask

    task automatic test_random_frames();
        int target;
        target = valid_cmds + RANDOM_CMDS;
        while (valid_cmds < target)
            run_frame();
        wait_all_writes(SETTLE_CYCLES);
    endtask

    task automatic test_back_to_back();
        int target;
        no_idle = 1'b1;
        target = valid_cmds + FINAL_CMDS;
        while (valid_cmds < target)
            run_frame();
        wait_all_writes(END_CYCLES);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_bus_frames();
        test_odd_commands();
        test_queue_fill();
        test_random_frames();
        test_back_to_back();
        if (expected_writes.size() != 0)
            fail_count++;
        $display("tb_top: %0d commands sent, %0d pin writes checked, %0d offers refused by full",
                 cmds_sent, writes_seen, full_waits);
        $display("tb_top: covered every command kind, unused codes, out-of-order commands and stalls");
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
